### rtl/bcg_pkg.sv
package bcg_pkg;

  localparam int unsigned TimeWidth   = 32;
  localparam int unsigned WindowWidth = 16;
  localparam int unsigned EventWidth  = 4;
  localparam int unsigned CfgIdxWidth = 1;
  localparam int unsigned CfgDataWidth = WindowWidth;

  localparam logic [CfgIdxWidth-1:0] REG_ACTIVE_LEVEL = 1'd0;
  localparam logic [CfgIdxWidth-1:0] REG_WINDOW_MS    = 1'd1;

  localparam logic                   ACTIVE_LEVEL_RST = 1'b1;
  localparam logic [WindowWidth-1:0] WINDOW_MS_RST    = 16'd500;

  localparam logic [EventWidth-1:0] EV_RELEASED        = 4'd0;
  localparam logic [EventWidth-1:0] EV_CLICK           = 4'd1;
  localparam logic [EventWidth-1:0] EV_PRESSED         = 4'd2;
  localparam logic [EventWidth-1:0] EV_LONG_CLICK      = 4'd3;
  localparam logic [EventWidth-1:0] EV_UP              = 4'd4;
  localparam logic [EventWidth-1:0] EV_DOUBLE_CLICK    = 4'd5;
  localparam logic [EventWidth-1:0] EV_CLICK_CONFIRMED = 4'd6;
  localparam logic [EventWidth-1:0] EV_DOUBLE_PRESSED  = 4'd7;
  localparam logic [EventWidth-1:0] EV_LONG_PRESSED    = 4'd8;

  typedef struct packed {
    logic                   active_level;
    logic [WindowWidth-1:0] window_ms;
  } cfg_t;

endpackage

### rtl/bcg_if.sv
interface bcg_poll_if;
  logic                            valid;
  logic                            ready;
  logic                            level;
  logic [bcg_pkg::TimeWidth-1:0]   now_ms;

  modport source (output valid, output level, output now_ms, input ready);
  modport sink   (input valid, input level, input now_ms, output ready);
endinterface

interface bcg_event_if;
  logic                            valid;
  logic                            ready;
  logic [bcg_pkg::EventWidth-1:0]  event_res;

  modport source (output valid, output event_res, input ready);
  modport sink   (input valid, input event_res, output ready);
endinterface

### rtl/bcg_fsm.sv
module bcg_fsm (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             step,
  input  logic                             level,
  input  logic [bcg_pkg::TimeWidth-1:0]    now_ms,
  input  bcg_pkg::cfg_t                    cfg,
  output logic [bcg_pkg::EventWidth-1:0]   event_res
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DOWN1 = 3'd1;
  localparam logic [2:0] ST_GAP   = 3'd2;
  localparam logic [2:0] ST_DOWN2 = 3'd3;
  localparam logic [2:0] ST_LONG  = 3'd4;

  logic [2:0]                      state;
  logic [2:0]                      state_next;
  logic [bcg_pkg::TimeWidth-1:0]   start_time;
  logic [bcg_pkg::TimeWidth-1:0]   start_time_next;
  logic [bcg_pkg::TimeWidth-1:0]   window_end;
  logic                            pressed;
  logic                            in_win;

  assign pressed    = (level == cfg.active_level);
  assign window_end = start_time +
                      {{(bcg_pkg::TimeWidth-bcg_pkg::WindowWidth){1'b0}}, cfg.window_ms};
  assign in_win     = (now_ms < window_end);

  always_comb begin
    state_next      = state;
    start_time_next = start_time;
    event_res       = bcg_pkg::EV_RELEASED;
    unique case (state)
      ST_DOWN1: begin
        if (!pressed) begin
          state_next = ST_GAP;
          event_res  = bcg_pkg::EV_UP;
        end else if (in_win) begin
          event_res  = bcg_pkg::EV_PRESSED;
        end else begin
          state_next = ST_LONG;
          event_res  = bcg_pkg::EV_LONG_CLICK;
        end
      end
      ST_GAP: begin
        if (pressed) begin
          state_next = ST_DOWN2;
          event_res  = bcg_pkg::EV_DOUBLE_CLICK;
        end else if (in_win) begin
          event_res  = bcg_pkg::EV_RELEASED;
        end else begin
          state_next = ST_IDLE;
          event_res  = bcg_pkg::EV_CLICK_CONFIRMED;
        end
      end
      ST_DOWN2: begin
        if (pressed) begin
          event_res  = bcg_pkg::EV_DOUBLE_PRESSED;
        end else begin
          state_next = ST_IDLE;
          event_res  = bcg_pkg::EV_UP;
        end
      end
      ST_LONG: begin
        if (pressed) begin
          event_res  = bcg_pkg::EV_LONG_PRESSED;
        end else begin
          state_next = ST_IDLE;
          event_res  = bcg_pkg::EV_UP;
        end
      end
      default: begin
        start_time_next = now_ms;
        if (pressed) begin
          state_next = ST_DOWN1;
          event_res  = bcg_pkg::EV_CLICK;
        end else begin
          state_next = ST_IDLE;
          event_res  = bcg_pkg::EV_RELEASED;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      start_time <= '0;
    end else if (step) begin
      state      <= state_next;
      start_time <= start_time_next;
    end
  end

endmodule

### rtl/button_click_gesture_classifier.sv
// Channel    Dir  Payload             Transfer
// poll_in    in   level, now_ms       valid & ready
// event_out  out  event_res           valid & ready
// cfg        in   cfg_index, cfg_wdata  cfg_we
//
// One poll per cycle sustained while event_out.ready stays high; each poll gives one
// event after its transfer, passing the input register, then the event register.
// The classifier state updates as a poll leaves the input register.
// Reset is synchronous: state idle, start time zero, config at defaults.
// A stalled event register holds the input register; both stages fill before
// poll_in.ready drops.
module button_click_gesture_classifier (
  input  logic                                  clk,
  input  logic                                  rst,
  bcg_poll_if.sink                              poll_in,
  bcg_event_if.source                           event_out,
  input  logic                                  cfg_we,
  input  logic [bcg_pkg::CfgIdxWidth-1:0]       cfg_index,
  input  logic [bcg_pkg::CfgDataWidth-1:0]      cfg_wdata
);

  bcg_pkg::cfg_t                     cfg;
  logic                              in_valid;
  logic                              in_level;
  logic [bcg_pkg::TimeWidth-1:0]     in_now;
  logic                              out_valid;
  logic [bcg_pkg::EventWidth-1:0]    out_event;
  logic [bcg_pkg::EventWidth-1:0]    event_next;
  logic                              out_free;
  logic                              step;

  assign out_free      = !out_valid || event_out.ready;
  assign step          = in_valid && out_free;
  assign poll_in.ready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_level <= bcg_pkg::ACTIVE_LEVEL_RST;
      cfg.window_ms    <= bcg_pkg::WINDOW_MS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bcg_pkg::REG_ACTIVE_LEVEL: cfg.active_level <= cfg_wdata[0];
        bcg_pkg::REG_WINDOW_MS:    cfg.window_ms    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (poll_in.ready) begin
      in_valid <= poll_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll_in.valid && poll_in.ready) begin
      in_level <= poll_in.level;
      in_now   <= poll_in.now_ms;
    end
  end

  bcg_fsm u_fsm (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .level     (in_level),
    .now_ms    (in_now),
    .cfg       (cfg),
    .event_res (event_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_event <= event_next;
    end
  end

  assign event_out.valid     = out_valid;
  assign event_out.event_res = out_event;

endmodule

### tb/bcg_gesture_checker.sv
`timescale 1ns / 1ps

module bcg_gesture_checker (
  input  logic                             clk,
  input  logic                             rst,
  bcg_poll_if                              poll_mon,
  bcg_event_if                             event_mon,
  input  logic                             cfg_we,
  input  logic [bcg_pkg::CfgIdxWidth-1:0]  cfg_index,
  input  logic [bcg_pkg::CfgDataWidth-1:0] cfg_wdata,
  output int                               events_owed,
  output int                               mismatches
);

  typedef enum logic [2:0] {
    G_IDLE,
    G_FIRST_DOWN,
    G_GAP,
    G_SECOND_DOWN,
    G_HOLD
  } gesture_e;

  gesture_e                         gst;
  logic [bcg_pkg::TimeWidth-1:0]    start_ms;
  logic                             act_lvl;
  logic [bcg_pkg::WindowWidth-1:0]  win_ms;
  logic [bcg_pkg::EventWidth-1:0]   predicted_events[$];
  int                               err_cnt;

  task automatic classify_poll(input logic lv, input logic [bcg_pkg::TimeWidth-1:0] t,
                               output logic [bcg_pkg::EventWidth-1:0] ev);
    logic                          pressed;
    logic [bcg_pkg::TimeWidth-1:0] win_end;
    logic                          in_win;
    pressed = (lv == act_lvl);
    win_end = start_ms +
              {{(bcg_pkg::TimeWidth-bcg_pkg::WindowWidth){1'b0}}, win_ms};
    in_win  = t < win_end;
    case (gst)
      G_FIRST_DOWN: begin
        if (!pressed) begin
          gst = G_GAP;
          ev  = bcg_pkg::EV_UP;
        end else if (in_win) begin
          ev = bcg_pkg::EV_PRESSED;
        end else begin
          gst = G_HOLD;
          ev  = bcg_pkg::EV_LONG_CLICK;
        end
      end
      G_GAP: begin
        if (pressed) begin
          gst = G_SECOND_DOWN;
          ev  = bcg_pkg::EV_DOUBLE_CLICK;
        end else if (in_win) begin
          ev = bcg_pkg::EV_RELEASED;
        end else begin
          gst = G_IDLE;
          ev  = bcg_pkg::EV_CLICK_CONFIRMED;
        end
      end
      G_SECOND_DOWN: begin
        if (pressed) begin
          ev = bcg_pkg::EV_DOUBLE_PRESSED;
        end else begin
          gst = G_IDLE;
          ev  = bcg_pkg::EV_UP;
        end
      end
      G_HOLD: begin
        if (pressed) begin
          ev = bcg_pkg::EV_LONG_PRESSED;
        end else begin
          gst = G_IDLE;
          ev  = bcg_pkg::EV_UP;
        end
      end
      default: begin
        start_ms = t;
        if (pressed) begin
          gst = G_FIRST_DOWN;
          ev  = bcg_pkg::EV_CLICK;
        end else begin
          gst = G_IDLE;
          ev  = bcg_pkg::EV_RELEASED;
        end
      end
    endcase
  endtask

  initial begin
    err_cnt = 0;
  end

  always @(posedge clk) begin
    logic [bcg_pkg::EventWidth-1:0] ev;
    logic [bcg_pkg::EventWidth-1:0] want;
    if (rst) begin
      gst      = G_IDLE;
      start_ms = '0;
      act_lvl  = bcg_pkg::ACTIVE_LEVEL_RST;
      win_ms   = bcg_pkg::WINDOW_MS_RST;
      predicted_events.delete();
    end else begin
      if (event_mon.valid && event_mon.ready) begin
        if (predicted_events.size() == 0) begin
          err_cnt++;
          $display("%0t: event transfer with none expected: got %0d", $time,
                   event_mon.event_res);
        end else begin
          want = predicted_events.pop_front();
          if (event_mon.event_res !== want) begin
            err_cnt++;
            $display("%0t: event_res mismatch: expected %0d, got %0d", $time, want,
                     event_mon.event_res);
          end
        end
      end
      if (poll_mon.valid && poll_mon.ready) begin
        classify_poll(poll_mon.level, poll_mon.now_ms, ev);
        predicted_events.push_back(ev);
      end
      if (cfg_we) begin
        case (cfg_index)
          bcg_pkg::REG_ACTIVE_LEVEL: act_lvl = cfg_wdata[0];
          bcg_pkg::REG_WINDOW_MS:    win_ms  = cfg_wdata[bcg_pkg::WindowWidth-1:0];
          default: ;
        endcase
      end
    end
    events_owed <= predicted_events.size();
    mismatches  <= err_cnt;
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CycleLimit  = 200000;
  localparam int          NumPhases   = 8;
  localparam int          PhaseItems  = 129;

  logic                             clk;
  logic                             rst;
  logic                             cfg_we;
  logic [bcg_pkg::CfgIdxWidth-1:0]  cfg_index;
  logic [bcg_pkg::CfgDataWidth-1:0] cfg_wdata;

  int                      events_owed;
  int                      mismatches;

  int unsigned             src_gap_pct;
  int unsigned             snk_stall_pct;
  bit                      hold_req;

  logic                             cur_act;
  logic [bcg_pkg::WindowWidth-1:0]  cur_win;
  logic [bcg_pkg::TimeWidth-1:0]    clock_ms;

  bcg_poll_if  poll_in ();
  bcg_event_if event_out ();

  button_click_gesture_classifier u_dut (
    .clk       (clk),
    .rst       (rst),
    .poll_in   (poll_in),
    .event_out (event_out),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  bcg_gesture_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .poll_mon    (poll_in),
    .event_mon   (event_out),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .events_owed (events_owed),
    .mismatches  (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles <= CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : sink_drv
    int stall_left;
    bit seen_hold;
    stall_left      = 0;
    seen_hold       = 1'b0;
    event_out.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != seen_hold) begin
        seen_hold  = hold_req;
        stall_left = 80;
      end
      if (rst) begin
        event_out.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        event_out.ready <= 1'b0;
      end else begin
        event_out.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
      end
    end
  end

  task automatic send_poll(input logic lv, input logic [bcg_pkg::TimeWidth-1:0] t);
    while ($urandom_range(0, 99) < src_gap_pct) begin
      poll_in.valid <= 1'b0;
      @(posedge clk);
    end
    poll_in.valid  <= 1'b1;
    poll_in.level  <= lv;
    poll_in.now_ms <= t;
    @(posedge clk);
    while (!poll_in.ready) @(posedge clk);
  endtask

  task automatic drain_events();
    poll_in.valid <= 1'b0;
    @(posedge clk);
    while (events_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bcg_pkg::CfgIdxWidth-1:0] idx,
                           input logic [bcg_pkg::CfgDataWidth-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_gestures(input int n);
    bit                            pressed;
    int                            run_left;
    int unsigned                   r;
    int unsigned                   w;
    logic [bcg_pkg::TimeWidth-1:0] step;
    logic                          lv;
    run_left = 0;
    pressed  = 1'b0;
    w        = 32'(cur_win);
    for (int i = 0; i < n; i++) begin
      if (run_left == 0) begin
        pressed  = ~pressed;
        if ($urandom_range(0, 9) == 0) pressed = 1'($urandom_range(0, 1));
        run_left = $urandom_range(1, 6);
      end
      r = $urandom_range(0, 99);
      if (r < 70)      step = $urandom_range(0, w / 4 + 1);
      else if (r < 90) step = $urandom_range(w / 2, w + w / 2 + 2);
      else if (r < 97) step = $urandom_range(w, 4 * w + 10);
      else             step = $urandom;
      clock_ms = clock_ms + step;
      lv = pressed ? cur_act : ~cur_act;
      if ($urandom_range(0, 19) == 0) lv = ~lv;
      send_poll(lv, clock_ms);
      run_left--;
    end
  endtask

  initial begin : stim
    logic                            act_tab [NumPhases];
    logic [bcg_pkg::WindowWidth-1:0] win_tab [NumPhases];
    act_tab = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
    win_tab = '{16'd500, 16'd65535, 16'd0, 16'd1, 16'd37, 16'd500, 16'd65535, 16'd2};

    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    poll_in.valid  = 1'b0;
    poll_in.level  = 1'b0;
    poll_in.now_ms = '0;
    src_gap_pct    = 0;
    snk_stall_pct  = 0;
    hold_req       = 1'b0;
    cur_act        = bcg_pkg::ACTIVE_LEVEL_RST;
    cur_win        = bcg_pkg::WINDOW_MS_RST;
    clock_ms       = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_poll(1'b0, 32'd0);
    send_poll(1'b1, 32'd10);
    send_poll(1'b1, 32'd100);
    send_poll(1'b0, 32'd200);
    send_poll(1'b1, 32'd300);
    send_poll(1'b1, 32'd400);
    send_poll(1'b0, 32'd450);
    send_poll(1'b1, 32'd1000);
    send_poll(1'b1, 32'd1500);
    send_poll(1'b1, 32'd2000);
    send_poll(1'b0, 32'd2001);
    send_poll(1'b1, 32'hFFFF_FF00);
    send_poll(1'b1, 32'hFFFF_FF10);
    send_poll(1'b0, 32'hFFFF_FFFF);
    send_poll(1'b1, 32'd0);
    send_poll(1'b0, 32'd5);
    send_poll(1'b0, 32'd100);
    send_poll(1'b0, 32'd500);
    drain_events();

    for (int p = 0; p < NumPhases; p++) begin
      if (p > 0) begin
        cur_act = act_tab[p];
        cur_win = win_tab[p];
        write_reg(bcg_pkg::REG_ACTIVE_LEVEL, {15'($urandom), cur_act});
        write_reg(bcg_pkg::REG_WINDOW_MS, cur_win);
      end
      if (p == 3) clock_ms = 32'hFFFF_F000;
      case (p % 4)
        0: begin
          src_gap_pct   <= 0;
          snk_stall_pct <= 0;
          hold_req      <= ~hold_req;
        end
        1: begin
          src_gap_pct   <= 77;
          snk_stall_pct <= 0;
        end
        2: begin
          src_gap_pct   <= 0;
          snk_stall_pct <= 77;
        end
        default: begin
          src_gap_pct   <= 21;
          snk_stall_pct <= 21;
        end
      endcase
      @(posedge clk);
      run_gestures(PhaseItems);
      drain_events();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && events_owed == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
rtl/bcg_pkg.sv
rtl/bcg_if.sv
rtl/bcg_fsm.sv
rtl/button_click_gesture_classifier.sv
tb/bcg_gesture_checker.sv
tb/tb.sv
